// ----- hdl/pts_pkg.sv -----
// Shared types, codes and constants of the periodic task scheduler.
package pts_pkg;

	// Field widths of the item ports.
	localparam int ACTION_W   = 3;
	localparam int ID_W       = 8;
	localparam int PERIOD_W   = 16;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 4;
	localparam int DIVIDE_W   = 16;

	// A dispatch fires at most this many tasks; the counter holds the limit itself.
	localparam int RESULT_LIMIT = 16;
	localparam int FIRED_CNT_W  = $clog2(RESULT_LIMIT + 1);

	// Reset value of the tick divide register.
	localparam logic [DIVIDE_W-1:0] DEFAULT_TICK_DIVIDE = 16'd392;

	// Action codes of an input item.
	localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DISPATCH = 3'd4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ADD_ACK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE_ACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FIRED      = 2'd3;

	// Reported status codes.
	localparam logic [STATUS_W-1:0] STATUS_RUNNABLE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_STOPPED   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} sched_state_t;

	// One slot as held in the slot memory.
	typedef struct packed {
		logic [ID_W-1:0]     task_id;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] countdown;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	// One result item without its end-of-run mark.
	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic                  success;
		logic [STATUS_W-1:0]   status;
		logic [ID_W-1:0]       fired_id;
		logic [SLOT_OUT_W-1:0] slot;
	} result_t;

	// Hand-over of a result from the slot engine to the output register.
	typedef struct packed {
		logic    valid;
		logic    last;
		result_t result;
	} push_t;

endpackage

// ----- hdl/pts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/pts_slot_engine.sv -----
// Slot engine: scans slot memory one slot a cycle, unless stalled, for scan actions.
module pts_slot_engine #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pts_pkg::ACTION_W-1:0]      action,
	input  logic [pts_pkg::ID_W-1:0]          task_id,
	input  logic [pts_pkg::PERIOD_W-1:0]      task_period,
	input  logic [pts_pkg::DIVIDE_W-1:0]      tick_divide,
	input  logic                              push_ready,
	output pts_pkg::push_t                    push
);

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

	pts_pkg::sched_state_t state_q, state_d;

	// Latched command.
	logic [pts_pkg::ACTION_W-1:0] act_q;
	logic [pts_pkg::ID_W-1:0]     id_q;
	logic [pts_pkg::PERIOD_W-1:0] period_q;

	// Scan pipeline: issue stage and data stage.
	logic [AW-1:0] rd_idx_q;
	logic          issue_done_q;
	logic          s2_valid_q;
	logic [AW-1:0] s2_idx_q;

	// Per-slot marks in flip-flops: runnable, and written since reset.
	logic [SLOT_COUNT-1:0] runnable_q;
	logic [SLOT_COUNT-1:0] written_q;

	logic [pts_pkg::DIVIDE_W-1:0]    prescale_q;
	logic [pts_pkg::FIRED_CNT_W-1:0] fired_cnt_q;
	logic                            pend_valid_q;
	pts_pkg::result_t                pend_q;

	// Memory interface.
	logic                  rd_en;
	logic                  wr_en;
	logic [pts_pkg::ENTRY_W-1:0] rd_data;
	pts_pkg::slot_entry_t  rd_entry;
	pts_pkg::slot_entry_t  eff;
	pts_pkg::slot_entry_t  wr_entry;

	// Command acceptance and prescaler.
	logic                          in_accept;
	logic                          start_scan;
	logic [pts_pkg::DIVIDE_W-1:0]  limit;
	logic [pts_pkg::DIVIDE_W:0]    prescale_next;
	logic                          tick_fire;

	// Data stage decisions.
	logic                          run_s2;
	logic                          last_s2;
	logic                          due;
	logic                          hold;
	logic                          proc;
	logic                          hit;
	logic                          term;
	logic                          issue;
	logic                          pend_load;
	pts_pkg::result_t              pend_d;
	logic                          set_run;
	logic                          clr_run;
	logic                          fired_inc;
	logic [AW+pts_pkg::SLOT_OUT_W-1:0] slot_ext;
	logic [pts_pkg::SLOT_OUT_W-1:0]    slot4;

	pts_ram #(
		.WIDTH (pts_pkg::ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (s2_idx_q),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	assign rd_entry = pts_pkg::slot_entry_t'(rd_data);

	// A slot never written since reset reads as all zero.
	assign eff = written_q[s2_idx_q] ? rd_entry : '0;

	assign in_stall  = (state_q != pts_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Prescaler: a divide of zero counts as one.
	assign limit         = (tick_divide == '0) ? 16'd1 : tick_divide;
	assign prescale_next = {1'b0, prescale_q} + 17'd1;
	assign tick_fire     = (prescale_next >= {1'b0, limit});

	// Actions that need a pass over the table.
	always_comb begin
		start_scan = 1'b0;
		unique case (action)
			pts_pkg::ACT_ADD,
			pts_pkg::ACT_DELETE,
			pts_pkg::ACT_QUERY,
			pts_pkg::ACT_DISPATCH: start_scan = 1'b1;
			pts_pkg::ACT_OVERFLOW: start_scan = tick_fire;
			default:               start_scan = 1'b0;
		endcase
	end

	assign run_s2   = runnable_q[s2_idx_q];
	assign last_s2  = (s2_idx_q == LAST_SLOT);
	assign slot_ext = {{pts_pkg::SLOT_OUT_W{1'b0}}, s2_idx_q};
	assign slot4    = slot_ext[pts_pkg::SLOT_OUT_W-1:0];
	assign due      = run_s2 && (eff.countdown == '0)
		&& (fired_cnt_q < pts_pkg::FIRED_CNT_W'(pts_pkg::RESULT_LIMIT));

	// A due slot whose predecessor result cannot leave stalls the whole scan.
	assign hold = s2_valid_q && (act_q == pts_pkg::ACT_DISPATCH) && due
		&& pend_valid_q && !push_ready;
	assign proc = s2_valid_q && !hold;

	// Per-slot work of the data stage.
	always_comb begin
		hit       = 1'b0;
		wr_en     = 1'b0;
		wr_entry  = eff;
		pend_load = 1'b0;
		pend_d    = '0;
		set_run   = 1'b0;
		clr_run   = 1'b0;
		fired_inc = 1'b0;
		if (proc) begin
			unique case (act_q)
				pts_pkg::ACT_ADD: begin
					hit               = !run_s2;
					wr_en             = hit;
					wr_entry.task_id  = id_q;
					wr_entry.period   = period_q;
					wr_entry.countdown = period_q;
					set_run           = hit;
					pend_load         = hit || last_s2;
					pend_d.kind       = pts_pkg::KIND_ADD_ACK;
					pend_d.success    = hit;
					pend_d.status     = pts_pkg::STATUS_RUNNABLE;
					pend_d.slot       = hit ? slot4 : '0;
				end
				pts_pkg::ACT_DELETE: begin
					hit            = (eff.task_id == id_q);
					clr_run        = hit;
					pend_load      = hit || last_s2;
					pend_d.kind    = pts_pkg::KIND_DELETE_ACK;
					pend_d.success = hit;
					pend_d.status  = pts_pkg::STATUS_RUNNABLE;
					pend_d.slot    = hit ? slot4 : '0;
				end
				pts_pkg::ACT_QUERY: begin
					hit            = (eff.task_id == id_q);
					pend_load      = hit || last_s2;
					pend_d.kind    = pts_pkg::KIND_STATUS;
					pend_d.success = hit;
					if (!hit) begin
						pend_d.status = pts_pkg::STATUS_NOT_FOUND;
					end else if (run_s2) begin
						pend_d.status = pts_pkg::STATUS_RUNNABLE;
					end else begin
						pend_d.status = pts_pkg::STATUS_STOPPED;
					end
					pend_d.slot = hit ? slot4 : '0;
				end
				pts_pkg::ACT_OVERFLOW: begin
					wr_en              = run_s2 && (eff.countdown != '0);
					wr_entry.countdown = eff.countdown - 16'd1;
				end
				pts_pkg::ACT_DISPATCH: begin
					wr_en              = due;
					wr_entry.countdown = eff.period;
					pend_load          = due;
					pend_d.kind        = pts_pkg::KIND_FIRED;
					pend_d.success     = 1'b1;
					pend_d.status      = pts_pkg::STATUS_RUNNABLE;
					pend_d.fired_id    = eff.task_id;
					pend_d.slot        = slot4;
					fired_inc          = due;
				end
				default: begin
					hit = 1'b0;
				end
			endcase
		end
	end

	assign term  = proc && (hit || last_s2);
	assign issue = (state_q == pts_pkg::ST_SCAN) && !issue_done_q && !hold && !term;
	assign rd_en = issue;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pts_pkg::ST_IDLE: begin
				if (in_accept && start_scan) begin
					state_d = pts_pkg::ST_SCAN;
				end
			end
			pts_pkg::ST_SCAN: begin
				if (term) begin
					state_d = pts_pkg::ST_FINISH;
				end
			end
			pts_pkg::ST_FINISH: begin
				if (!pend_valid_q || push_ready) begin
					state_d = pts_pkg::ST_IDLE;
				end
			end
			default: state_d = pts_pkg::ST_IDLE;
		endcase
	end

	// Result hand-over: earlier fired results during the scan, the held one at the end.
	always_comb begin
		push = '0;
		unique case (state_q)
			pts_pkg::ST_SCAN: begin
				push.valid  = proc && (act_q == pts_pkg::ACT_DISPATCH) && due && pend_valid_q;
				push.last   = 1'b0;
				push.result = pend_q;
			end
			pts_pkg::ST_FINISH: begin
				push.valid  = pend_valid_q && push_ready;
				push.last   = 1'b1;
				push.result = pend_q;
			end
			default: push = '0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pts_pkg::ST_IDLE;
			issue_done_q <= 1'b0;
			s2_valid_q   <= 1'b0;
			rd_idx_q     <= '0;
			s2_idx_q     <= '0;
			runnable_q   <= '0;
			written_q    <= '0;
			prescale_q   <= '0;
			fired_cnt_q  <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				if (action == pts_pkg::ACT_OVERFLOW) begin
					prescale_q <= tick_fire ? '0 : prescale_next[pts_pkg::DIVIDE_W-1:0];
				end
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
				s2_valid_q   <= 1'b0;
				fired_cnt_q  <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				if (issue) begin
					s2_valid_q <= 1'b1;
					s2_idx_q   <= rd_idx_q;
					if (rd_idx_q == LAST_SLOT) begin
						issue_done_q <= 1'b1;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end else if (!hold) begin
					s2_valid_q <= 1'b0;
				end
				if (term) begin
					issue_done_q <= 1'b1;
				end
				if (pend_load) begin
					pend_valid_q <= 1'b1;
				end else if (state_q == pts_pkg::ST_FINISH && push.valid) begin
					pend_valid_q <= 1'b0;
				end
				if (fired_inc) begin
					fired_cnt_q <= fired_cnt_q + pts_pkg::FIRED_CNT_W'(1);
				end
				if (set_run) begin
					runnable_q[s2_idx_q] <= 1'b1;
					written_q[s2_idx_q]  <= 1'b1;
				end
				if (clr_run) begin
					runnable_q[s2_idx_q] <= 1'b0;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q    <= action;
			id_q     <= task_id;
			period_q <= task_period;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
	end

endmodule

// ----- hdl/pts_result_reg.sv -----
// Output register that holds one result item until the receiver takes it.
module pts_result_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  pts_pkg::push_t   push,
	output logic             push_ready,
	output logic             out_valid,
	input  logic             out_stall,
	output pts_pkg::result_t out_result,
	output logic             out_last
);

	logic             valid_q;
	pts_pkg::result_t result_q;
	logic             last_q;

	// Free when empty or when the held item leaves this cycle.
	assign push_ready = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign out_result = result_q;
	assign out_last   = last_q;

	// Occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Held item.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			result_q <= push.result;
			last_q   <= push.last;
		end
	end

endmodule

// ----- hdl/periodic_task_scheduler_unit.sv -----
// Top level of the periodic task scheduler: configuration register, slot engine, output register.
//
// Every add, delete, query, dispatch and tick-completing timer overflow walks the slot table
// in slot order, one slot per cycle unless a dispatch is stalled, through the single read port
// of the slot memory, whose read data is registered; the final result is handed over from a
// finish state. Add, delete and query stop at the first hit. A timer overflow that does not
// complete a tick, and an undefined action code, do not walk the table. A dispatch walk
// stalls while the output is stalled and a further due task is found. No new item is taken
// until the current one has handed over its last result. The runnable and written marks sit
// in flip-flops cleared at reset, so the block is ready straight out of reset with no clearing
// pass. tick_divide should only be written while the block is idle.
module periodic_task_scheduler_unit #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pts_pkg::DIVIDE_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pts_pkg::ACTION_W-1:0]       action,
	input  logic [pts_pkg::ID_W-1:0]           task_id,
	input  logic [pts_pkg::PERIOD_W-1:0]       task_period,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pts_pkg::KIND_W-1:0]         result_kind,
	output logic                               success,
	output logic [pts_pkg::STATUS_W-1:0]       reported_status,
	output logic [pts_pkg::ID_W-1:0]           fired_task_id,
	output logic [pts_pkg::SLOT_OUT_W-1:0]     slot_index,
	output logic                               last_of_run
);

	logic [pts_pkg::DIVIDE_W-1:0] tick_divide_q;
	pts_pkg::push_t               push;
	logic                         push_ready;
	pts_pkg::result_t             out_result;

	// The tick divide register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divide_q <= pts_pkg::DEFAULT_TICK_DIVIDE;
		end else if (cfg_valid && cfg_ready) begin
			tick_divide_q <= cfg_data;
		end
	end

	pts_slot_engine #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.task_id     (task_id),
		.task_period (task_period),
		.tick_divide (tick_divide_q),
		.push_ready  (push_ready),
		.push        (push)
	);

	pts_result_reg u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_result (out_result),
		.out_last   (last_of_run)
	);

	// Spread the held result over the field ports.
	assign result_kind     = out_result.kind;
	assign success         = out_result.success;
	assign reported_status = out_result.status;
	assign fired_task_id   = out_result.fired_id;
	assign slot_index      = out_result.slot;

endmodule
